### src/utf8s_pkg.sv
// Shared types and constants for the UTF-8 stream sanitizer.
// Used by utf8s_core, utf8s_emit and the top level; depends on nothing.
`default_nettype none

package utf8s_pkg;

  localparam int MAX_RES = 4;

  // control_mode codes; code 3 acts as MODE_QUERY
  localparam logic [1:0] MODE_KEEP_CRLF = 2'd0;
  localparam logic [1:0] MODE_QUERY     = 2'd1;
  localparam logic [1:0] MODE_SPACE     = 2'd2;

  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [20:0] CP_MIN2    = 21'h00080;
  localparam logic [20:0] CP_MIN3    = 21'h00800;
  localparam logic [20:0] CP_MIN4    = 21'h10000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO = 21'h0D800;
  localparam logic [20:0] CP_SURR_HI = 21'h0DFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       replaced;
    logic       invalid;
    logic       last;
  } res_t;

  // group of results caused by one item; count is 0..4
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [2:0]         count;
  } grp_t;

endpackage

`default_nettype wire

### src/utf8s_core.sv
// Input register, sequence state and decode of one item into a result group.
// Depends on utf8s_pkg.
`default_nettype none

module utf8s_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire logic [1:0]        mode,
  input  wire logic              grp_ready,
  output utf8s_pkg::grp_t        grp,
  output logic                   grp_load
);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_last;

  logic [7:0]  pend [3];
  logic [1:0]  pend_count;
  logic [2:0]  exp_len;
  logic [20:0] partial_cp;
  logic        invalid_seen;

  logic [1:0]  pend_count_next;
  logic [2:0]  exp_len_next;
  logic [20:0] partial_cp_next;
  logic        invalid_seen_next;
  logic        pend_we;
  logic [1:0]  pend_idx;

  logic        advance;

  utf8s_pkg::grp_t g;

  logic        is_cont;
  logic [20:0] cp_shift;
  logic [20:0] cp_min;
  logic        bad_cp;
  logic        complete;

  assign is_cont  = (item_byte[7:6] == 2'b10);
  assign cp_shift = {partial_cp[14:0], item_byte[5:0]};
  assign complete = ({1'b0, pend_count} + 3'd1) >= exp_len;

  always_comb begin
    case (exp_len)
      3'd2:    cp_min = utf8s_pkg::CP_MIN2;
      3'd3:    cp_min = utf8s_pkg::CP_MIN3;
      default: cp_min = utf8s_pkg::CP_MIN4;
    endcase
  end

  assign bad_cp = (cp_shift < cp_min) || (cp_shift > utf8s_pkg::CP_MAX) ||
                  ((cp_shift >= utf8s_pkg::CP_SURR_LO) && (cp_shift <= utf8s_pkg::CP_SURR_HI));

  always_comb begin
    logic       lead;
    logic       inv;
    logic [2:0] n;
    logic [7:0] o;
    lead = 1'b0;
    inv  = invalid_seen;
    n    = 3'd0;
    o    = item_byte;
    g    = '0;
    pend_count_next = pend_count;
    exp_len_next    = exp_len;
    partial_cp_next = partial_cp;
    pend_we  = 1'b0;
    pend_idx = pend_count;

    if (pend_count != 2'd0) begin
      if (is_cont) begin
        if (complete) begin
          if (bad_cp) begin
            // every held byte plus this one becomes a replaced '?'
            inv = 1'b1;
            for (int i = 0; i < utf8s_pkg::MAX_RES; i++) begin
              if (i <= int'(pend_count)) begin
                g.res[i] = '{utf8s_pkg::CH_QUERY, 1'b1, 1'b1, 1'b0};
              end
            end
            n = {1'b0, pend_count} + 3'd1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (i < int'(pend_count)) begin
                g.res[i] = '{pend[i], 1'b0, inv, 1'b0};
              end
            end
            g.res[pend_count] = '{item_byte, 1'b0, inv, 1'b0};
            n = {1'b0, pend_count} + 3'd1;
          end
          pend_count_next = 2'd0;
          exp_len_next    = 3'd0;
          partial_cp_next = '0;
        end else begin
          pend_we         = 1'b1;
          pend_count_next = pend_count + 2'd1;
          partial_cp_next = cp_shift;
          if (item_last) begin
            inv = 1'b1;
            for (int i = 0; i < utf8s_pkg::MAX_RES; i++) begin
              if (i <= int'(pend_count)) begin
                g.res[i] = '{utf8s_pkg::CH_QUERY, 1'b1, 1'b1, 1'b0};
              end
            end
            n = {1'b0, pend_count} + 3'd1;
          end
        end
      end else begin
        // broken sequence: flush held bytes, then treat byte as a lead
        inv = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (i < int'(pend_count)) begin
            g.res[i] = '{utf8s_pkg::CH_QUERY, 1'b1, 1'b1, 1'b0};
          end
        end
        n = {1'b0, pend_count};
        pend_count_next = 2'd0;
        exp_len_next    = 3'd0;
        partial_cp_next = '0;
        lead = 1'b1;
      end
    end else begin
      lead = 1'b1;
    end

    if (lead) begin
      if (!item_byte[7]) begin
        if (item_byte < utf8s_pkg::CH_SPACE) begin
          if (mode == utf8s_pkg::MODE_KEEP_CRLF) begin
            if (item_byte == utf8s_pkg::CH_TAB) begin
              o = utf8s_pkg::CH_SPACE;
            end else if (item_byte != utf8s_pkg::CH_CR && item_byte != utf8s_pkg::CH_LF) begin
              o = utf8s_pkg::CH_QUERY;
            end
          end else if (mode == utf8s_pkg::MODE_SPACE) begin
            o = utf8s_pkg::CH_SPACE;
          end else begin
            o = utf8s_pkg::CH_QUERY;
          end
        end
        g.res[n[1:0]] = '{o, 1'b0, inv, 1'b0};
        n = n + 3'd1;
      end else if (item_byte >= 8'hC2 && item_byte <= 8'hF4) begin
        pend_we         = 1'b1;
        pend_idx        = 2'd0;
        pend_count_next = 2'd1;
        if (item_byte <= 8'hDF) begin
          exp_len_next    = 3'd2;
          partial_cp_next = {16'd0, item_byte[4:0]};
        end else if (item_byte <= 8'hEF) begin
          exp_len_next    = 3'd3;
          partial_cp_next = {17'd0, item_byte[3:0]};
        end else begin
          exp_len_next    = 3'd4;
          partial_cp_next = {18'd0, item_byte[2:0]};
        end
        if (item_last) begin
          inv = 1'b1;
          g.res[n[1:0]] = '{utf8s_pkg::CH_QUERY, 1'b1, 1'b1, 1'b0};
          n = n + 3'd1;
        end
      end else begin
        inv = 1'b1;
        g.res[n[1:0]] = '{utf8s_pkg::CH_QUERY, 1'b1, 1'b1, 1'b0};
        n = n + 3'd1;
      end
    end

    invalid_seen_next = inv;
    if (item_last) begin
      if (n != 3'd0) begin
        g.res[2'(n - 3'd1)].last = 1'b1;
      end
      pend_count_next   = 2'd0;
      exp_len_next      = 3'd0;
      partial_cp_next   = '0;
      invalid_seen_next = 1'b0;
    end
    g.count = n;
  end

  // an item with no results retires without waiting on the output side
  assign advance  = item_valid && ((g.count == 3'd0) || grp_ready);
  assign grp_load = advance && (g.count != 3'd0);
  assign grp      = g;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      pend_count   <= 2'd0;
      exp_len      <= 3'd0;
      partial_cp   <= '0;
      invalid_seen <= 1'b0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        pend_count   <= pend_count_next;
        exp_len      <= exp_len_next;
        partial_cp   <= partial_cp_next;
        invalid_seen <= invalid_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_byte <= in_byte;
      item_last <= in_last;
    end
    if (advance && pend_we) begin
      pend[pend_idx] <= item_byte;
    end
  end

endmodule

`default_nettype wire

### src/utf8s_emit.sv
// Result group register: holds up to four results of one item and hands
// them out one per cycle while out_stall is low. Depends on utf8s_pkg.
`default_nettype none

module utf8s_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire utf8s_pkg::grp_t grp_in,
  input  wire logic            grp_load,
  output logic                 grp_ready,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output utf8s_pkg::res_t      res
);

  utf8s_pkg::grp_t grp;
  logic [1:0]      idx;
  logic            pop;
  logic            last_pop;

  assign pop       = out_valid && !out_stall;
  assign last_pop  = pop && ({1'b0, idx} == (grp.count - 3'd1));
  assign grp_ready = !out_valid || last_pop;
  assign res       = grp.res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (grp_load) begin
      out_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (last_pop) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp <= grp_in;
    end
  end

endmodule

`default_nettype wire

### src/utf8_stream_sanitizer.sv
// UTF-8 stream sanitizer, top level: mode register, decode core, result group.
// Depends on utf8s_pkg, utf8s_core and utf8s_emit.
// Path: an accepted item passes the input register, then the result group
//   register; it waits in the input register while the result group is busy.
// Throughput: one item per cycle while each item yields at most one result and
//   out_stall is low; an item yielding several results holds the output port until its last is taken.
// Reset (synchronous): mode 0, sequence state and invalid flag cleared,
//   no result pending; no clearing pass.
`default_nettype none

module utf8_stream_sanitizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_replaced,
  output logic            any_invalid,
  output logic            out_last,
  input  wire logic       control_mode_valid,
  output logic            control_mode_ready,
  input  wire logic [1:0] control_mode
);

  logic [1:0]      mode;
  utf8s_pkg::grp_t grp;
  logic            grp_load;
  logic            grp_ready;
  utf8s_pkg::res_t res;

  assign control_mode_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= utf8s_pkg::MODE_KEEP_CRLF;
    end else if (control_mode_valid && control_mode_ready) begin
      mode <= control_mode;
    end
  end

  utf8s_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .mode      (mode),
    .grp_ready (grp_ready),
    .grp       (grp),
    .grp_load  (grp_load)
  );

  utf8s_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp_in    (grp),
    .grp_load  (grp_load),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_byte     = res.data;
  assign out_replaced = res.replaced;
  assign any_invalid  = res.invalid;
  assign out_last     = res.last;

endmodule

`default_nettype wire

### bench/tb_utf8_stream_sanitizer.sv
// Testbench for utf8_stream_sanitizer: directed and random UTF-8 text, checked
// against a built-in byte-level sanitizer model with random stalls on both sides.
// Depends on utf8s_pkg and the utf8_stream_sanitizer RTL.
module tb_utf8_stream_sanitizer;
  timeunit 1ns;
  timeprecision 1ps;

  // register code 3 decodes like MODE_QUERY
  localparam logic [1:0] MODE_ALT_QUERY = 2'd3;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_replaced;
  logic       any_invalid;
  logic       out_last;
  logic       control_mode_valid;
  logic       control_mode_ready;
  logic [1:0] control_mode;

  utf8_stream_sanitizer u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_replaced       (out_replaced),
    .any_invalid        (any_invalid),
    .out_last           (out_last),
    .control_mode_valid (control_mode_valid),
    .control_mode_ready (control_mode_ready),
    .control_mode       (control_mode)
  );

  // sanitizer model state
  logic [1:0]  ctl_mode;
  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  seq_len;
  logic [20:0] cp_acc;
  logic        text_invalid;

  utf8s_pkg::res_t sanitized_q [$];
  utf8s_pkg::res_t step_q [$];
  logic [7:0] chunk_q [$];

  int sender_idle_pct;
  int recv_idle_pct;
  int err_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void emit_byte(input logic [7:0] b, input logic replaced);
    utf8s_pkg::res_t r;
    r.data     = b;
    r.replaced = replaced;
    r.invalid  = text_invalid;
    r.last     = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void clear_sequence();
    held_count = '0;
    seq_len    = '0;
    cp_acc     = '0;
  endfunction

  // replace every held byte with '?'
  function automatic void flush_held(input int count);
    text_invalid = 1'b1;
    repeat (count) emit_byte(utf8s_pkg::CH_QUERY, 1'b1);
    clear_sequence();
  endfunction

  function automatic void start_char(input logic [7:0] b, input logic last);
    logic [7:0] o;
    o = b;
    if (b < 8'h80) begin
      if (b < utf8s_pkg::CH_SPACE) begin
        if (ctl_mode == utf8s_pkg::MODE_KEEP_CRLF) begin
          if (b == utf8s_pkg::CH_TAB) o = utf8s_pkg::CH_SPACE;
          else if (b != utf8s_pkg::CH_CR && b != utf8s_pkg::CH_LF) o = utf8s_pkg::CH_QUERY;
        end else if (ctl_mode == utf8s_pkg::MODE_SPACE) begin
          o = utf8s_pkg::CH_SPACE;
        end else begin
          o = utf8s_pkg::CH_QUERY;
        end
      end
      emit_byte(o, 1'b0);
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) begin
      seq_len = 3'd2;
      cp_acc  = {16'd0, b[4:0]};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      seq_len = 3'd3;
      cp_acc  = {17'd0, b[3:0]};
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      seq_len = 3'd4;
      cp_acc  = {18'd0, b[2:0]};
    end else begin
      text_invalid = 1'b1;
      emit_byte(utf8s_pkg::CH_QUERY, 1'b1);
      return;
    end
    held_bytes[0] = b;
    held_count    = 2'd1;
    if (last) flush_held(int'(held_count));
  endfunction

  // work out the results of one accepted byte and queue them
  function automatic void sanitize_step(input logic [7:0] b, input logic last);
    logic [20:0] cp_min;
    step_q.delete();
    if (held_count != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        if (int'(held_count) + 1 >= int'(seq_len)) begin
          cp_min = (seq_len == 3'd2) ? utf8s_pkg::CP_MIN2 :
                   (seq_len == 3'd3) ? utf8s_pkg::CP_MIN3 : utf8s_pkg::CP_MIN4;
          if (cp_acc < cp_min || cp_acc > utf8s_pkg::CP_MAX ||
              (cp_acc >= utf8s_pkg::CP_SURR_LO && cp_acc <= utf8s_pkg::CP_SURR_HI)) begin
            flush_held(int'(held_count) + 1);
          end else begin
            for (int i = 0; i < int'(held_count); i++) emit_byte(held_bytes[i], 1'b0);
            emit_byte(b, 1'b0);
            clear_sequence();
          end
        end else begin
          held_bytes[held_count] = b;
          held_count = held_count + 2'd1;
          if (last) flush_held(int'(held_count));
        end
      end else begin
        flush_held(int'(held_count));
        start_char(b, last);
      end
    end else begin
      start_char(b, last);
    end
    if (last) begin
      if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
      clear_sequence();
      text_invalid = 1'b0;
    end
    foreach (step_q[i]) sanitized_q.push_back(step_q[i]);
  endfunction

  task automatic check_result();
    utf8s_pkg::res_t got;
    utf8s_pkg::res_t want;
    got = '{out_byte, out_replaced, any_invalid, out_last};
    if (sanitized_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("mismatch: unexpected result byte=%h replaced=%b invalid=%b last=%b",
                 got.data, got.replaced, got.invalid, got.last);
    end else begin
      want = sanitized_q.pop_front();
      if (got.data !== want.data || got.replaced !== want.replaced ||
          got.invalid !== want.invalid || got.last !== want.last) begin
        err_count++;
        if (err_count <= 10)
          $display({"mismatch: expected byte=%h replaced=%b invalid=%b last=%b, ",
                    "got byte=%h replaced=%b invalid=%b last=%b"},
                   want.data, want.replaced, want.invalid, want.last,
                   got.data, got.replaced, got.invalid, got.last);
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sanitize_step(b, last);
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$], input logic last_on_end);
    foreach (bytes[i]) send_byte(bytes[i], last_on_end && i == bytes.size() - 1);
  endtask

  // drain all results, then let a possible lead byte in flight settle
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] value);
    wait_quiet();
    control_mode_valid = 1'b1;
    control_mode       = value;
    forever begin
      @(posedge clk);
      if (control_mode_ready) break;
    end
    ctl_mode = value;
    @(negedge clk);
    control_mode_valid = 1'b0;
  endtask

  task automatic test_control_chars();
    write_mode(utf8s_pkg::MODE_KEEP_CRLF);
    send_bytes({8'h00, utf8s_pkg::CH_TAB, utf8s_pkg::CH_LF, utf8s_pkg::CH_CR, 8'h7F}, 1'b1);
    write_mode(utf8s_pkg::MODE_QUERY);
    send_bytes({utf8s_pkg::CH_TAB}, 1'b1);
    write_mode(utf8s_pkg::MODE_SPACE);
    send_bytes({utf8s_pkg::CH_CR}, 1'b1);
    write_mode(MODE_ALT_QUERY);
    send_bytes({8'h1F}, 1'b1);
  endtask

  task automatic test_valid_sequences();
    write_mode(utf8s_pkg::MODE_KEEP_CRLF);
    send_bytes({8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBD, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b1);
  endtask

  task automatic test_invalid_sequences();
    // bad leads, overlong, surrogate, then a sequence broken by ASCII
    send_bytes({8'hFF, 8'h80, 8'hE0, 8'h9F, 8'hBF, 8'hED, 8'hA0, 8'h80,
                8'hC3, 8'h41}, 1'b1);
  endtask

  task automatic test_truncation();
    send_bytes({8'hE2, 8'h82}, 1'b1);
    send_bytes({8'hF0}, 1'b1);
  endtask

  function automatic void push_codepoint(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        chunk_q.push_back({3'b110, cp[10:6]});
      end
      3: begin
        chunk_q.push_back({4'b1110, cp[15:12]});
        chunk_q.push_back({2'b10, cp[11:6]});
      end
      default: begin
        chunk_q.push_back({5'b11110, cp[20:18]});
        chunk_q.push_back({2'b10, cp[17:12]});
        chunk_q.push_back({2'b10, cp[11:6]});
      end
    endcase
    chunk_q.push_back({2'b10, cp[5:0]});
  endfunction

  function automatic logic [7:0] valid_lead(input int len);
    case (len)
      2:       return 8'($urandom_range(8'hC2, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  // mostly well-formed characters, some broken or malformed ones, some noise
  function automatic void make_chunk();
    int kind;
    int len;
    logic [20:0] cp;
    logic [7:0] tricky_leads [8];
    tricky_leads = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hFF};
    chunk_q.delete();
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    if (kind < 35) begin
      chunk_q.push_back(8'($urandom_range(0, 8'h7F)));
    end else if (kind < 65) begin
      if (len == 2) begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (len == 3) begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= utf8s_pkg::CP_SURR_LO && cp <= utf8s_pkg::CP_SURR_HI) cp = cp - 21'h800;
      end else begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end
      push_codepoint(cp, len);
    end else if (kind < 78) begin
      chunk_q.push_back(valid_lead(len));
      repeat ($urandom_range(0, len - 2)) chunk_q.push_back({2'b10, 6'($urandom)});
      if ($urandom_range(0, 1)) chunk_q.push_back(8'($urandom_range(0, 8'h7F)));
      else chunk_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end else if (kind < 90) begin
      if ($urandom_range(0, 1)) chunk_q.push_back(tricky_leads[$urandom_range(0, 7)]);
      else chunk_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
      repeat (3) chunk_q.push_back({2'b10, 6'($urandom)});
    end else begin
      chunk_q.push_back(8'($urandom));
    end
  endfunction

  task automatic test_random_text(input int n_bytes, input int snd_pct, input int rcv_pct);
    int sent;
    logic ended;
    logic [7:0] b;
    sender_idle_pct = snd_pct;
    recv_idle_pct   = rcv_pct;
    sent  = 0;
    ended = 1'b1;
    while (sent < n_bytes) begin
      make_chunk();
      while (chunk_q.size() != 0) begin
        b     = chunk_q.pop_front();
        ended = ($urandom_range(0, 99) < 6);
        send_byte(b, ended);
        sent++;
      end
    end
    // close the text so the block is idle for the next register write
    if (!ended) send_byte(8'h41, 1'b1);
  endtask

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    in_byte            = '0;
    in_last            = 1'b0;
    out_stall          = 1'b0;
    control_mode_valid = 1'b0;
    control_mode       = utf8s_pkg::MODE_KEEP_CRLF;
    sender_idle_pct    = 6;
    recv_idle_pct      = 49;
    err_count          = 0;
    ctl_mode           = utf8s_pkg::MODE_KEEP_CRLF;
    text_invalid       = 1'b0;
    clear_sequence();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_control_chars();
    test_valid_sequences();
    test_invalid_sequences();
    test_truncation();

    write_mode(utf8s_pkg::MODE_SPACE);
    test_random_text(50, 6, 49);
    write_mode(MODE_ALT_QUERY);
    test_random_text(50, 49, 6);
    write_mode(utf8s_pkg::MODE_KEEP_CRLF);
    test_random_text(50, 0, 0);

    in_valid = 1'b0;
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
